FILE: rtl/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Shared widths, register indexes, operation codes and types of the
// nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
package nns_pkg;

	localparam int DIM_W     = 13;
	localparam int COORD_W   = 12;
	localparam int IDX_W     = 12;
	localparam int PIX_W     = 32;
	localparam int CFG_IDX_W = 3;

	localparam int STORE_PIXELS_DEF = 4096;
	localparam int FRAC_BITS_DEF    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE = 3'd4;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [PIX_W-1:0] RGB_MASK = 32'h00FF_FFFF;

	typedef enum logic [1:0] {
		RAT_IDLE,
		RAT_START,
		RAT_X,
		RAT_Y
	} rat_state_t;

endpackage

FILE: rtl/nns_if.sv
// ----------------------------------------------------------------------------
// nns_if
// Channel interfaces of the scaler: request, response and register write.
// ----------------------------------------------------------------------------
interface nns_in_if import nns_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [IDX_W-1:0]   src_index;
	logic [PIX_W-1:0]   pixel_in;
	logic [COORD_W-1:0] dst_x;
	logic [COORD_W-1:0] dst_y;

	modport source (output valid, operation, src_index, pixel_in, dst_x, dst_y, input ready);
	modport sink   (input valid, operation, src_index, pixel_in, dst_x, dst_y, output ready);
endinterface

interface nns_out_if import nns_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             outside;

	modport source (output valid, pixel_out, outside, input ready);
	modport sink   (input valid, pixel_out, outside, output ready);
endinterface

interface nns_cfg_if import nns_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/nns_ram.sv
// ----------------------------------------------------------------------------
// nns_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nns_ram import nns_pkg::*; #(
	parameter int WIDTH = PIX_W,
	parameter int DEPTH = STORE_PIXELS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/nns_div.sv
// ----------------------------------------------------------------------------
// nns_div
// Restoring divider, one quotient bit per cycle. Zero divisor gives zero.
// ----------------------------------------------------------------------------
module nns_div import nns_pkg::*; #(
	parameter int DIVIDEND_W = DIM_W + FRAC_BITS_DEF,
	parameter int DIVISOR_W  = DIM_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic                  zero_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;
	logic [DIVISOR_W-1:0]  rem_next;

	assign trial    = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign fits     = trial >= {1'b0, dvs_q};
	assign rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : quo_q;

endmodule

FILE: rtl/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Pixel store with nearest-neighbour lookup of scaled output pixels.
//
// req carries load and fetch items. A load writes pixel_in at src_index
// (indexes beyond the store are dropped) and returns nothing. A fetch maps
// dst_x, dst_y through the 13.FRAC_BITS ratios to a source pixel and returns one
// transfer on rsp: the pixel (zero past the store), top byte cleared unless
// alpha_mode is set, or zero with outside set when the coordinate is off
// the destination. cfg writes the size and alpha registers; keep it to idle
// periods. Pipeline: input register, two multiply stages, store read. One
// item per cycle is taken while the response side keeps up.
// When rsp stalls, the whole pipeline holds and req.ready drops.
// Each register write reruns the two ratio divisions, one after the other,
// on one bit-serial divider, with req.ready low meanwhile.
// Reset: registers to 1/1/1/1/0, ratios 1.0; store contents undefined.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler import nns_pkg::*; #(
	parameter int STORE_PIXELS = STORE_PIXELS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nns_in_if.sink     req,
	nns_out_if.source  rsp,
	nns_cfg_if.sink    cfg
);

	localparam int AW     = $clog2(STORE_PIXELS);
	localparam int RW     = DIM_W + FRAC_BITS;
	localparam int PW     = COORD_W + RW;
	localparam int SW     = PW - FRAC_BITS;
	localparam int ROW_W  = SW + DIM_W;
	localparam int SIDX_W = ROW_W + 1;
	localparam logic [RW-1:0]     RATIO_ONE = RW'(1) << FRAC_BITS;
	localparam logic [SIDX_W-1:0] STORE_LIM = SIDX_W'(STORE_PIXELS);

	// registers
	logic [DIM_W-1:0] src_width_q;
	logic [DIM_W-1:0] src_height_q;
	logic [DIM_W-1:0] dst_width_q;
	logic [DIM_W-1:0] dst_height_q;
	logic             alpha_q;
	logic [RW-1:0]    ratio_x_q;
	logic [RW-1:0]    ratio_y_q;
	logic             cfg_fire;
	logic             cfg_hit;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg_hit   = cfg_fire && (cfg.index inside {[REG_SRC_WIDTH:REG_ALPHA_MODE]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_W'(1);
			src_height_q <= DIM_W'(1);
			dst_width_q  <= DIM_W'(1);
			dst_height_q <= DIM_W'(1);
			alpha_q      <= 1'b0;
		end else if (cfg_fire) begin
			case (cfg.index)
				REG_SRC_WIDTH:  src_width_q  <= cfg.data;
				REG_SRC_HEIGHT: src_height_q <= cfg.data;
				REG_DST_WIDTH:  dst_width_q  <= cfg.data;
				REG_DST_HEIGHT: dst_height_q <= cfg.data;
				REG_ALPHA_MODE: alpha_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ratio sequencer
	rat_state_t    state_q;
	rat_state_t    state_d;
	logic          div_start;
	logic          div_done;
	logic          sel_y;
	logic          lat_x;
	logic          lat_y;
	logic          ratios_ok;
	logic [RW-1:0] div_dividend;
	logic [DIM_W-1:0] div_divisor;
	logic [RW-1:0] div_quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RAT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			RAT_IDLE:  state_d = RAT_IDLE;
			RAT_START: state_d = RAT_X;
			RAT_X:     if (div_done) state_d = RAT_Y;
			RAT_Y:     if (div_done) state_d = RAT_IDLE;
			default:   state_d = RAT_IDLE;
		endcase
		if (cfg_hit) begin
			state_d = RAT_START;
		end
	end

	always_comb begin
		div_start = 1'b0;
		sel_y     = 1'b0;
		lat_x     = 1'b0;
		lat_y     = 1'b0;
		ratios_ok = 1'b0;
		case (state_q)
			RAT_IDLE:  ratios_ok = 1'b1;
			RAT_START: div_start = 1'b1;
			RAT_X: begin
				sel_y     = 1'b1;
				div_start = div_done;
				lat_x     = div_done;
			end
			RAT_Y:     lat_y = div_done;
			default: ;
		endcase
	end

	assign div_dividend = sel_y ? {src_height_q, {FRAC_BITS{1'b0}}}
	                            : {src_width_q, {FRAC_BITS{1'b0}}};
	assign div_divisor  = sel_y ? dst_height_q : dst_width_q;

	nns_div #(
		.DIVIDEND_W (RW),
		.DIVISOR_W  (DIM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_x_q <= RATIO_ONE;
			ratio_y_q <= RATIO_ONE;
		end else begin
			if (lat_x) ratio_x_q <= div_quotient;
			if (lat_y) ratio_y_q <= div_quotient;
		end
	end

	// pixel pipeline
	logic advance;
	logic take;

	logic               v_s1, op_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [COORD_W-1:0] x_s1, y_s1;

	logic               v_s2, op_s2, outside_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [PIX_W-1:0]   pix_s2;
	logic [SW-1:0]      sx_s2, sy_s2;

	logic               v_s3, op_s3, outside_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic [PIX_W-1:0]   pix_s3;
	logic [SW-1:0]      sx_s3;
	logic [ROW_W-1:0]   row_s3;

	logic               v_s4, outside_s4, in_store_s4;

	logic [PW-1:0]      prod_x, prod_y;
	logic [SIDX_W-1:0]  sidx;
	logic               in_store;
	logic               idx_ok;
	logic               ram_we;
	logic [PIX_W-1:0]   ram_rdata;

	assign advance   = !v_s4 || rsp.ready;
	assign req.ready = advance && ratios_ok;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && (op_s3 == OP_FETCH);
		end
	end

	assign prod_x = PW'(x_s1) * PW'(ratio_x_q);
	assign prod_y = PW'(y_s1) * PW'(ratio_y_q);

	assign sidx     = SIDX_W'(row_s3) + SIDX_W'(sx_s3);
	assign in_store = sidx < STORE_LIM;
	assign idx_ok   = int'(idx_s3) < STORE_PIXELS;
	assign ram_we   = advance && v_s3 && (op_s3 == OP_LOAD) && idx_ok;

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1  <= req.operation;
			idx_s1 <= req.src_index;
			pix_s1 <= req.pixel_in;
			x_s1   <= req.dst_x;
			y_s1   <= req.dst_y;

			op_s2      <= op_s1;
			idx_s2     <= idx_s1;
			pix_s2     <= pix_s1;
			sx_s2      <= prod_x[PW-1:FRAC_BITS];
			sy_s2      <= prod_y[PW-1:FRAC_BITS];
			outside_s2 <= ({1'b0, x_s1} >= dst_width_q) || ({1'b0, y_s1} >= dst_height_q);

			op_s3      <= op_s2;
			idx_s3     <= idx_s2;
			pix_s3     <= pix_s2;
			sx_s3      <= sx_s2;
			row_s3     <= ROW_W'(sy_s2) * ROW_W'(src_width_q);
			outside_s3 <= outside_s2;

			outside_s4  <= outside_s3;
			in_store_s4 <= in_store;
		end
	end

	nns_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(idx_s3)),
		.wdata (pix_s3),
		.re    (advance),
		.raddr (sidx[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign rsp.valid     = v_s4;
	assign rsp.outside   = outside_s4;
	assign rsp.pixel_out = (outside_s4 || !in_store_s4) ? '0
	                     : (alpha_q ? ram_rdata : (ram_rdata & RGB_MASK));

endmodule
